// File: design/tod_counter_with_alarm_macros.svh
// assertion macros for the time-of-day counter with alarm
`ifndef TOD_COUNTER_WITH_ALARM_MACROS_SVH
`define TOD_COUNTER_WITH_ALARM_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define TCWA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define TCWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCWA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TCWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/tcwa_pkg.sv
// shared types and constants of the time-of-day counter with alarm
`timescale 1ns / 1ps

package tcwa_pkg;

    // item commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // register selects
    localparam logic [2:0] SEL_CNT_LO = 3'd0;
    localparam logic [2:0] SEL_CNT_MI = 3'd1;
    localparam logic [2:0] SEL_CNT_HI = 3'd2;
    localparam logic [2:0] SEL_ALM_LO = 3'd3;
    localparam logic [2:0] SEL_ALM_MI = 3'd4;
    localparam logic [2:0] SEL_ALM_HI = 3'd5;

    localparam logic [23:0] COUNT_RESET = 24'h010000;
    localparam logic [11:0] LOW_ALL_ONES = 12'hFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  reg_sel;
        logic [7:0]  write_data;
        logic [47:0] time_stamp;
        logic        frozen;
        logic        stopped;
        logic [23:0] latch_value;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } t_result;

    // pick one byte of a 24-bit word, zero for selects past the top byte
    function automatic logic [7:0] get_byte(input logic [23:0] word, input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // replace one byte of a 24-bit word
    function automatic logic [23:0] put_byte(input logic [23:0] word, input logic [1:0] sel,
                                             input logic [7:0] b);
        logic [23:0] w;
        unique case (sel)
            2'd0:    w = {word[23:8], b};
            2'd1:    w = {word[23:16], b, word[7:0]};
            2'd2:    w = {b, word[15:0]};
            default: w = word;
        endcase
        return w;
    endfunction

endpackage

// File: design/tcwa_in_reg.sv
// input register stage holding one accepted beat
`timescale 1ns / 1ps

module tcwa_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tcwa_pkg::t_item i_item,
    output logic           o_stall,
    input  logic           i_take,
    output logic           o_valid,
    output tcwa_pkg::t_item o_item
);
    import tcwa_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    // stall only while a held beat cannot move on
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: design/tcwa_core.sv
// counter, alarm and time-stamp state with the per-beat update logic
`timescale 1ns / 1ps

module tcwa_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    input  logic             i_advance,
    input  tcwa_pkg::t_item   i_item,
    output tcwa_pkg::t_result o_result,
    output logic             o_match
);
    import tcwa_pkg::*;

    logic        r_tod_bug;
    logic [23:0] r_count;
    logic [23:0] r_alarm;
    logic [23:0] r_prev;
    logic [47:0] r_last_tick;
    logic        r_match;

    logic [23:0] n_count;
    logic [23:0] n_alarm;
    logic [23:0] n_prev;
    logic [47:0] n_last_tick;
    logic        n_match;

    logic [23:0] mid_count;
    logic        mid_eq;
    logic        match_mid;
    logic        eq_final;
    logic        rose_mid;
    logic [23:0] rd_src;
    logic        cnt_sel;
    logic        alm_sel;

    always_comb begin
        n_count     = r_count;
        n_alarm     = r_alarm;
        n_prev      = r_prev;
        n_last_tick = r_last_tick;
        n_match     = r_match;
        o_result    = '0;
        cnt_sel     = (i_item.reg_sel == SEL_CNT_LO) || (i_item.reg_sel == SEL_CNT_MI)
                      || (i_item.reg_sel == SEL_CNT_HI);
        alm_sel     = (i_item.reg_sel == SEL_ALM_LO) || (i_item.reg_sel == SEL_ALM_MI)
                      || (i_item.reg_sel == SEL_ALM_HI);
        // mid-carry view: low 12 bits cleared, upper part not yet bumped
        mid_count   = {r_count[23:12], 12'h000};
        mid_eq      = (mid_count == r_alarm);
        rose_mid    = 1'b0;
        match_mid   = r_match;
        eq_final    = 1'b0;
        rd_src      = r_count;

        unique case (i_item.cmd)
            CMD_TICK: begin
                if (!i_item.stopped) begin
                    n_prev      = r_count;
                    n_last_tick = i_item.time_stamp;
                    if (r_tod_bug && (r_count[11:0] == LOW_ALL_ONES)) begin
                        rose_mid  = mid_eq && !r_match;
                        match_mid = mid_eq;
                    end
                    n_count      = r_count + 24'd1;
                    eq_final     = (n_count == r_alarm);
                    n_match      = eq_final;
                    o_result.irq = rose_mid || (eq_final && !match_mid);
                end
            end
            CMD_READ: begin
                if (i_item.frozen) begin
                    rd_src = i_item.latch_value;
                end else if (i_item.time_stamp > r_last_tick) begin
                    rd_src = r_count;
                end else begin
                    rd_src = r_prev;
                end
                if (cnt_sel) begin
                    o_result.read_data = get_byte(rd_src, i_item.reg_sel[1:0]);
                end else if (alm_sel) begin
                    o_result.read_data = get_byte(r_alarm, 2'(i_item.reg_sel - SEL_ALM_LO));
                end
            end
            CMD_WRITE: begin
                if (cnt_sel) begin
                    n_count = put_byte(r_count, i_item.reg_sel[1:0], i_item.write_data);
                end else if (alm_sel) begin
                    n_alarm = put_byte(r_alarm, 2'(i_item.reg_sel - SEL_ALM_LO),
                                       i_item.write_data);
                end
                if (cnt_sel || alm_sel) begin
                    eq_final     = (n_count == n_alarm);
                    n_match      = eq_final;
                    o_result.irq = eq_final && !r_match;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tod_bug <= 1'b0;
        end else if (i_cfg_we) begin
            r_tod_bug <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RESET;
            r_alarm     <= '0;
            r_prev      <= '0;
            r_last_tick <= '0;
            r_match     <= 1'b1;
        end else if (i_advance) begin
            r_count     <= n_count;
            r_alarm     <= n_alarm;
            r_prev      <= n_prev;
            r_last_tick <= n_last_tick;
            r_match     <= n_match;
        end
    end

    assign o_match = r_match;

endmodule

// File: design/tcwa_out_reg.sv
// result register stage facing the output channel
`timescale 1ns / 1ps

module tcwa_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tcwa_pkg::t_result i_result,
    output logic             o_free,
    input  logic             i_stall,
    output logic             o_valid,
    output tcwa_pkg::t_result o_result
);
    import tcwa_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/tod_counter_with_alarm.sv
// top level of the 24-bit time-of-day counter with alarm compare
// a beat accepted into the input register is processed by the core as it moves into
// the result register, from which its result beat is taken on the output channel
// throughput: one beat per cycle while the consumer does not stall; the only loop is the
// counter/alarm state update, which closes between input and result registers
// reset: synchronous active low; count 0x010000, alarm and history zero, match set
`timescale 1ns / 1ps

`include "tod_counter_with_alarm_macros.svh"

module tod_counter_with_alarm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_reg_sel,
    input  logic [7:0]  i_write_data,
    input  logic [47:0] i_time_stamp,
    input  logic        i_frozen,
    input  logic        i_stopped,
    input  logic [23:0] i_latch_value,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_irq,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import tcwa_pkg::*;

    t_item   in_beat;
    t_item   held_item;
    logic    held_valid;
    t_result core_res;
    t_result out_res;
    logic    out_free;
    logic    advance;
    logic    core_match;
    logic    cfg_we;

    // gather the input fields into one beat
    assign in_beat = '{
        cmd:         i_cmd,
        reg_sel:     i_reg_sel,
        write_data:  i_write_data,
        time_stamp:  i_time_stamp,
        frozen:      i_frozen,
        stopped:     i_stopped,
        latch_value: i_latch_value
    };

    // configuration is taken at any time; the user must land it only while idle, unenforced
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // the held beat is processed and its state update committed in the
    // same cycle it moves into the result register
    assign advance = held_valid && out_free;

    tcwa_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_beat),
        .o_stall (o_stall),
        .i_take  (advance),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // counter, alarm, tick history and match flag live here
    tcwa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_item     (held_item),
        .o_result   (core_res),
        .o_match    (core_match)
    );

    // result register decouples a stalled consumer from the next beat
    tcwa_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_res),
        .o_free   (out_free),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_res)
    );

    assign o_read_data = out_res.read_data;
    assign o_irq       = out_res.irq;

    // checks on the block's own logic

    // a read never raises the alarm interrupt
    `TCWA_ASSERT_NEXT(a_read_no_irq, i_clk, i_rst_n,
        advance && (held_item.cmd == CMD_READ), o_valid && !o_irq,
        "read beat produced an interrupt")

    // back-pressure only when a beat is actually held
    `TCWA_ASSERT_SAME(a_stall_needs_beat, i_clk, i_rst_n,
        o_stall, held_valid,
        "input stalled with an empty input register")

    // an interrupt from a write leaves the match flag set
    // (a tick may rise at the mid-carry check and still end unmatched)
    `TCWA_ASSERT_NEXT(a_irq_sets_match, i_clk, i_rst_n,
        advance && core_res.irq && (held_item.cmd == CMD_WRITE), core_match,
        "write interrupt raised without a stored match")

endmodule
